// ----- rtl/fbpx_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpx_pkg
// Shared constants for the framed byte parser: start byte, default payload
// depth, result status codes and parser phase codes.
// ----------------------------------------------------------------------------
package fbpx_pkg;

    localparam int unsigned MAX_DATA_DEF = 16;

    localparam logic [7:0] START_BYTE = 8'hAA;

    localparam logic [1:0] ST_RECV    = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_ERR     = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CHK  = 3'd4;

endpackage

// ----- rtl/framed_byte_parser_xor_timeout_core.sv -----
// ----------------------------------------------------------------------------
// framed_byte_parser_xor_timeout_core
// Start/command/length/payload/XOR-checksum frame parser with inter-byte
// timeout; payload bytes are buffered in a one-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one received byte and its 32-bit arrival stamp per
//   transaction. m_* channel returns results: every byte gives one result
//   (status receiving, error or timeout), except the checksum byte of a good
//   frame, which gives one result per payload byte (one if the length is 0).
//   m_run_end marks the last result caused by a byte.
//   cfg_we/cfg_wdata write the gap limit (0 disables the timeout check).
// Latency: a single result is valid in the cycle after its byte is accepted;
//   the first payload result of a good frame follows one payload RAM read, then the load of the output register.
// Throughput: one byte per cycle while results are taken. After a good frame
//   of length N > 0 the input stalls while the N results are produced, each
//   by one payload RAM read, then the load of the output register.
// Reset: parser hunts for the start byte, gap limit and last stamp are zero,
//   no result is pending. The payload RAM is not cleared; an entry is only
//   read after the frame wrote it.
// Stall: a result not taken holds in the output register and s_ready drops
//   until it is taken.
// ----------------------------------------------------------------------------
module framed_byte_parser_xor_timeout_core #(
    parameter int unsigned MAX_DATA = fbpx_pkg::MAX_DATA_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_stamp,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_frame_command,
    output logic [4:0]  m_frame_length,
    output logic [7:0]  m_data_byte,
    output logic [3:0]  m_data_position,
    output logic        m_run_end
);

    localparam int unsigned ADDR_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int unsigned LEN_W  = $clog2(MAX_DATA + 1);

    // parser state
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [7:0]       xor_reg, xor_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [31:0]      gap_limit_reg;

    // emit sequencer
    logic             emit_reg, emit_next;
    logic             pend_reg, pend_next;
    logic [LEN_W-1:0] ecnt_reg, ecnt_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       ocmd_reg, ocmd_next;
    logic [4:0]       olen_reg, olen_next;
    logic [7:0]       odata_reg, odata_next;
    logic [3:0]       opos_reg, opos_next;
    logic             oend_reg, oend_next;

    // payload RAM
    logic [7:0]        mem [MAX_DATA];
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata_reg;

    logic              in_fire;
    logic              out_free;
    logic [31:0]       gap;
    logic              timeout;
    logic [LEN_W:0]    fill_inc;
    logic [LEN_W:0]    ecnt_inc;
    logic              emit_last;
    logic [LEN_W+4:0]  len_ext;
    logic [LEN_W+3:0]  pos_ext;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !emit_reg && out_free;
    assign in_fire   = s_valid && s_ready;

    assign gap       = s_stamp - stamp_reg;
    assign timeout   = (phase_reg != fbpx_pkg::PH_HUNT) && (gap_limit_reg != 32'd0)
                       && (gap > gap_limit_reg);
    assign fill_inc  = (LEN_W+1)'(fill_reg) + (LEN_W+1)'(1);
    assign ecnt_inc  = (LEN_W+1)'(ecnt_reg) + (LEN_W+1)'(1);
    assign emit_last = (ecnt_inc == (LEN_W+1)'(len_reg));
    assign len_ext   = (LEN_W+5)'(len_reg);
    assign pos_ext   = (LEN_W+4)'(ecnt_reg);

    assign mem_waddr = fill_reg[ADDR_W-1:0];
    assign mem_raddr = ecnt_reg[ADDR_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        xor_next     = xor_reg;
        stamp_next   = stamp_reg;
        emit_next    = emit_reg;
        pend_next    = pend_reg;
        ecnt_next    = ecnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        ocmd_next    = ocmd_reg;
        olen_next    = olen_reg;
        odata_next   = odata_reg;
        opos_next    = opos_reg;
        oend_next    = oend_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (in_fire) begin
            m_valid_next = 1'b1;
            status_next  = fbpx_pkg::ST_RECV;
            ocmd_next    = 8'd0;
            olen_next    = 5'd0;
            odata_next   = 8'd0;
            opos_next    = 4'd0;
            oend_next    = 1'b1;
            if (timeout) begin
                status_next = fbpx_pkg::ST_TIMEOUT;
                stamp_next  = s_stamp;
                phase_next  = (s_rx_byte == fbpx_pkg::START_BYTE) ?
                              fbpx_pkg::PH_CMD : fbpx_pkg::PH_HUNT;
            end else begin
                unique case (phase_reg)
                    fbpx_pkg::PH_HUNT: begin
                        stamp_next = s_stamp;
                        if (s_rx_byte == fbpx_pkg::START_BYTE) begin
                            phase_next = fbpx_pkg::PH_CMD;
                        end
                    end
                    fbpx_pkg::PH_CMD: begin
                        stamp_next = s_stamp;
                        cmd_next   = s_rx_byte;
                        xor_next   = s_rx_byte;
                        phase_next = fbpx_pkg::PH_LEN;
                    end
                    fbpx_pkg::PH_LEN: begin
                        if ({1'b0, s_rx_byte} > 9'(MAX_DATA)) begin
                            status_next = fbpx_pkg::ST_ERR;
                            phase_next  = fbpx_pkg::PH_HUNT;
                        end else begin
                            stamp_next = s_stamp;
                            len_next   = s_rx_byte[LEN_W-1:0];
                            xor_next   = xor_reg ^ s_rx_byte;
                            fill_next  = '0;
                            phase_next = (s_rx_byte == 8'd0) ?
                                         fbpx_pkg::PH_CHK : fbpx_pkg::PH_DATA;
                        end
                    end
                    fbpx_pkg::PH_DATA: begin
                        stamp_next = s_stamp;
                        mem_we     = 1'b1;
                        fill_next  = fill_inc[LEN_W-1:0];
                        xor_next   = xor_reg ^ s_rx_byte;
                        if (fill_inc >= (LEN_W+1)'(len_reg)) begin
                            phase_next = fbpx_pkg::PH_CHK;
                        end
                    end
                    fbpx_pkg::PH_CHK: begin
                        phase_next = fbpx_pkg::PH_HUNT;
                        if (s_rx_byte == xor_reg) begin
                            stamp_next  = s_stamp;
                            status_next = fbpx_pkg::ST_GOOD;
                            ocmd_next   = cmd_reg;
                            olen_next   = len_ext[4:0];
                            if (len_reg != '0) begin
                                // payload run: results come from the sequencer
                                m_valid_next = 1'b0;
                                emit_next    = 1'b1;
                                pend_next    = 1'b0;
                                ecnt_next    = '0;
                            end
                        end else begin
                            status_next = fbpx_pkg::ST_ERR;
                        end
                    end
                    default: begin
                        stamp_next = s_stamp;
                        phase_next = fbpx_pkg::PH_HUNT;
                    end
                endcase
            end
        end else if (emit_reg) begin
            if (!pend_reg) begin
                mem_re    = 1'b1;
                pend_next = 1'b1;
            end else if (out_free) begin
                m_valid_next = 1'b1;
                status_next  = fbpx_pkg::ST_GOOD;
                ocmd_next    = cmd_reg;
                olen_next    = len_ext[4:0];
                odata_next   = mem_rdata_reg;
                opos_next    = pos_ext[3:0];
                oend_next    = emit_last;
                pend_next    = 1'b0;
                ecnt_next    = ecnt_inc[LEN_W-1:0];
                if (emit_last) begin
                    emit_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= fbpx_pkg::PH_HUNT;
            cmd_reg       <= '0;
            len_reg       <= '0;
            fill_reg      <= '0;
            xor_reg       <= '0;
            stamp_reg     <= '0;
            gap_limit_reg <= '0;
            emit_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            ecnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            fill_reg    <= fill_next;
            xor_reg     <= xor_next;
            stamp_reg   <= stamp_next;
            emit_reg    <= emit_next;
            pend_reg    <= pend_next;
            ecnt_reg    <= ecnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                gap_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        ocmd_reg   <= ocmd_next;
        olen_reg   <= olen_next;
        odata_reg  <= odata_next;
        opos_reg   <= opos_next;
        oend_reg   <= oend_next;
    end

    // payload RAM; writes finish before the checksum byte, so no forwarding
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_frame_command = ocmd_reg;
    assign m_frame_length  = olen_reg;
    assign m_data_byte     = odata_reg;
    assign m_data_position = opos_reg;
    assign m_run_end       = oend_reg;

`ifndef NO_ASSERTIONS
    a_no_input_during_run: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reg |-> !s_ready)
        else $error("input accepted during payload run");

    a_run_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reg |-> (ecnt_reg < len_reg))
        else $error("payload run index beyond frame length");

    a_single_result_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != fbpx_pkg::ST_GOOD) |-> m_run_end)
        else $error("non-good result without run end");

    a_run_end_stops_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_run_end && !in_fire) |=> !emit_reg)
        else $error("payload run continues after run end");

    a_good_frame_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !timeout && phase_reg == fbpx_pkg::PH_CHK
         && s_rx_byte == xor_reg && len_reg != '0) |=> (emit_reg && !m_valid))
        else $error("good frame did not start payload run");
`endif

endmodule

// ----- test/tb_framed_byte_parser_xor_timeout_core.sv -----
// ----------------------------------------------------------------------------
// tb_framed_byte_parser_xor_timeout_core
// Self-checking bench for the framed byte parser. A scoreboard class tracks
// the parser state, the payload buffer and the gap limit. It predicts every
// result of each accepted byte and compares results in order. Directed
// frames cover the corner cases. Random well-formed, corrupted, truncated
// and late frames follow under several gap limits and handshake pressures.
// ----------------------------------------------------------------------------
typedef struct {
    logic [1:0] status;
    logic [7:0] command;
    logic [4:0] length;
    logic [7:0] data;
    logic [3:0] position;
    logic       run_end;
} parse_result_t;

typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_LONG,
    FR_CUT,
    FR_LATE,
    FR_NOISE
} frame_kind_t;

class parse_scoreboard;
    logic [31:0]   gap_limit;
    logic [31:0]   last_stamp;
    logic [2:0]    phase;
    logic [7:0]    command;
    logic [4:0]    length;
    logic [7:0]    xsum;
    logic [7:0]    payload [fbpx_pkg::MAX_DATA_DEF];
    int unsigned   fill;
    parse_result_t due_results[$];
    int            errors;

    function new();
        clear_frame();
        last_stamp = '0;
        gap_limit  = '0;
        errors     = 0;
    endfunction

    function void clear_frame();
        phase   = fbpx_pkg::PH_HUNT;
        command = '0;
        length  = '0;
        xsum    = '0;
        fill    = 0;
    endfunction

    function void set_gap_limit(logic [31:0] v);
        gap_limit = v;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void push_single(logic [1:0] st);
        parse_result_t r;
        r = '{st, 8'd0, 5'd0, 8'd0, 4'd0, 1'b1};
        due_results.push_back(r);
    endfunction

    function void accept_byte(logic [7:0] b, logic [31:0] t);
        parse_result_t r;
        logic [31:0]   gap;
        int            n;
        gap = t - last_stamp;
        if (phase != fbpx_pkg::PH_HUNT && gap_limit != 0 && gap > gap_limit) begin
            clear_frame();
            last_stamp = t;
            if (b == fbpx_pkg::START_BYTE) phase = fbpx_pkg::PH_CMD;
            push_single(fbpx_pkg::ST_TIMEOUT);
            return;
        end
        case (phase)
            fbpx_pkg::PH_HUNT: begin
                if (b == fbpx_pkg::START_BYTE) phase = fbpx_pkg::PH_CMD;
            end
            fbpx_pkg::PH_CMD: begin
                command = b;
                xsum    = b;
                phase   = fbpx_pkg::PH_LEN;
            end
            fbpx_pkg::PH_LEN: begin
                if (b > fbpx_pkg::MAX_DATA_DEF) begin
                    clear_frame();
                    push_single(fbpx_pkg::ST_ERR);
                    return;
                end
                length = b[4:0];
                xsum   = xsum ^ b;
                fill   = 0;
                phase  = (b == 0) ? fbpx_pkg::PH_CHK : fbpx_pkg::PH_DATA;
            end
            fbpx_pkg::PH_DATA: begin
                if (fill < fbpx_pkg::MAX_DATA_DEF) payload[fill] = b;
                fill++;
                xsum = xsum ^ b;
                if (fill >= length) phase = fbpx_pkg::PH_CHK;
            end
            fbpx_pkg::PH_CHK: begin
                if (b == xsum) begin
                    n = (length == 0) ? 1 : int'(length);
                    last_stamp = t;
                    for (int k = 0; k < n; k++) begin
                        r.status   = fbpx_pkg::ST_GOOD;
                        r.command  = command;
                        r.length   = length;
                        r.data     = (length == 0) ? 8'd0 : payload[k];
                        r.position = (length == 0) ? 4'd0 : 4'(k);
                        r.run_end  = (k == n - 1);
                        due_results.push_back(r);
                    end
                    clear_frame();
                    return;
                end
                clear_frame();
                push_single(fbpx_pkg::ST_ERR);
                return;
            end
            default: begin
                clear_frame();
            end
        endcase
        last_stamp = t;
        push_single(fbpx_pkg::ST_RECV);
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] g);
        if (g !== e) begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, g);
            errors++;
        end
    endfunction

    function void check_result(parse_result_t got);
        parse_result_t e;
        if (due_results.size() == 0) begin
            $error("result with status %0d arrived with nothing outstanding", got.status);
            errors++;
            return;
        end
        e = due_results.pop_front();
        check_field("status", e.status, got.status);
        check_field("frame_command", e.command, got.command);
        check_field("frame_length", e.length, got.length);
        check_field("data_byte", e.data, got.data);
        check_field("data_position", e.position, got.position);
        check_field("run_end", e.run_end, got.run_end);
    endfunction
endclass

module tb_framed_byte_parser_xor_timeout_core;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic [31:0] s_stamp   = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_frame_command;
    logic [4:0]  m_frame_length;
    logic [7:0]  m_data_byte;
    logic [3:0]  m_data_position;
    logic        m_run_end;

    parse_scoreboard sb = new();
    parse_result_t   seen;

    int unsigned send_idle = 25;
    int unsigned recv_idle = 68;
    int unsigned hold_left = 0;
    int unsigned sent      = 0;
    logic [31:0] rx_time   = '0;

    always #2 aclk = ~aclk;

    framed_byte_parser_xor_timeout_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_stamp         (s_stamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_frame_command (m_frame_command),
        .m_frame_length  (m_frame_length),
        .m_data_byte     (m_data_byte),
        .m_data_position (m_data_position),
        .m_run_end       (m_run_end)
    );

    // result side: ready pattern and long hold-off, counted here
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.status   = m_status;
            seen.command  = m_frame_command;
            seen.length   = m_frame_length;
            seen.data     = m_data_byte;
            seen.position = m_data_position;
            seen.run_end  = m_run_end;
            sb.check_result(seen);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        s_stamp   <= t;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.accept_byte(b, t);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_at(input logic [7:0] b, input logic [31:0] d);
        rx_time = rx_time + d;
        send_byte(b, rx_time);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_gap_limit(input logic [31:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_gap_limit(v);
    endtask

    function automatic logic [31:0] pick_delta(input bit late);
        logic [31:0] g;
        int unsigned r;
        g = sb.gap_limit;
        r = $urandom_range(0, 99);
        if (late) return g + 32'd1 + $urandom_range(0, 3);
        if (g == 0) return $urandom();
        if (r < 80) return $urandom_range(0, (g < 40) ? g : 40);
        if (r < 92) return g;
        if (r < 96) return g + 32'd1;
        return $urandom();
    endfunction

    function automatic int pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 4);
        if (r < 90) return $urandom_range(5, 15);
        return fbpx_pkg::MAX_DATA_DEF;
    endfunction

    function automatic frame_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return FR_GOOD;
        if (r < 65) return FR_BAD_SUM;
        if (r < 73) return FR_LONG;
        if (r < 83) return FR_CUT;
        if (r < 93) return FR_LATE;
        return FR_NOISE;
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  bytes_q[$];
        logic [7:0]  cmd;
        logic [7:0]  pay;
        logic [7:0]  sum;
        int          n;
        int          stop_at;
        int          late_at;
        cmd = $urandom();
        n   = pick_length();
        sum = cmd ^ 8'(n);
        bytes_q = '{fbpx_pkg::START_BYTE, cmd, 8'(n)};
        for (int i = 0; i < n; i++) begin
            pay = $urandom();
            sum = sum ^ pay;
            bytes_q.push_back(pay);
        end
        if (kind == FR_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        bytes_q.push_back(sum);
        stop_at = bytes_q.size();
        late_at = -1;
        case (kind)
            FR_NOISE: begin
                bytes_q.delete();
                repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom()));
                stop_at = bytes_q.size();
            end
            FR_LONG: begin
                bytes_q[2] = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                         : 8'($urandom_range(17, 255));
                stop_at = 3;
            end
            FR_CUT: begin
                stop_at = $urandom_range(1, bytes_q.size() - 1);
            end
            FR_LATE: begin
                late_at = $urandom_range(1, bytes_q.size() - 1);
                if ($urandom_range(0, 1) == 1) bytes_q[late_at] = fbpx_pkg::START_BYTE;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < stop_at; i++) begin
            send_at(bytes_q[i], pick_delta(i == late_at));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = sent + count;
        while (sent < target) send_frame(pick_kind());
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, timeout off
        write_gap_limit(32'd0);
        send_at(8'h00, 32'd0);
        send_at(8'hFF, 32'hFFFF_FFFF);
        send_at(fbpx_pkg::START_BYTE, 32'd1);
        send_at(8'h00, 32'd1);
        send_at(8'h00, 32'd1);
        send_at(8'h00, 32'd1);
        send_at(fbpx_pkg::START_BYTE, 32'd1);
        send_at(8'hFF, 32'd1);
        send_at(8'h11, 32'd1);
        send_at(fbpx_pkg::START_BYTE, 32'd1);
        send_at(8'h5A, 32'd1);
        send_at(8'h01, 32'd1);
        send_at(8'hFF, 32'd1);
        send_at(8'h00, 32'd1);
        send_at(fbpx_pkg::START_BYTE, 32'd1);
        send_at(8'h3C, 32'd1);
        send_at(8'h02, 32'd1);
        send_at(8'hFF, 32'd1);
        send_at(8'h00, 32'd1);
        send_at(8'hC1, 32'd1);
        run_random(20);

        // tightest limit: timeout on a plain byte and on a start byte
        write_gap_limit(32'd1);
        send_at(fbpx_pkg::START_BYTE, 32'd1);
        send_at(8'h12, 32'd5);
        send_at(fbpx_pkg::START_BYTE, 32'd1);
        send_at(8'h34, 32'd1);
        send_at(fbpx_pkg::START_BYTE, 32'd9);
        send_at(8'h56, 32'd1);
        send_at(8'h00, 32'd1);
        send_at(8'h56, 32'd1);
        run_random(15);

        send_idle = 68;
        recv_idle = 25;
        write_gap_limit(32'hFFFF_FFFF);
        rx_time = 32'hFFFF_FFF0;
        run_random(15);

        write_gap_limit(32'h8000_0000);
        run_random(15);

        // back-pressure: results held off while bytes are offered without gaps
        send_idle = 0;
        recv_idle = 0;
        write_gap_limit(32'($urandom_range(2, 200)));
        hold_left = 150;
        run_random(20);

        write_gap_limit(32'd0);
        run_random(8);
        wait_idle();
        run_random(7);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
